FILE: hdl/vcc_pkg.sv
// ----------------------------------------------------------------------------
// Vector clock compare package
// Shared widths, codes and types of the vector clock comparator.
// ----------------------------------------------------------------------------
package vcc_pkg;

    // Field widths fixed by the item format.
    localparam int NODE_W = 15;
    localparam int CNT_W  = 64;
    localparam int OP_W   = 2;
    localparam int REL_W  = 2;

    // Default capacity of each clock.
    localparam int MAX_ENTRIES_DEF = 16;

    // Input operation codes.
    typedef enum logic [OP_W-1:0] {
        OP_CLEAR    = 2'd0,
        OP_APPEND_A = 2'd1,
        OP_APPEND_B = 2'd2,
        OP_COMPARE  = 2'd3
    } t_opcode;

    // Result relation codes.
    typedef enum logic [REL_W-1:0] {
        REL_EQUAL      = 2'd0,
        REL_BEFORE     = 2'd1,
        REL_AFTER      = 2'd2,
        REL_CONCURRENT = 2'd3
    } t_relation;

    // One stored clock entry.
    typedef struct packed {
        logic [NODE_W-1:0] node_id;
        logic [CNT_W-1:0]  counter;
    } t_entry;

    // Flags produced by the shared compare unit for one walk step.
    typedef struct packed {
        logic id_eq;
        logic id_a_lt;
        logic cnt_a_gt;
        logic cnt_b_gt;
    } t_cmp_res;

endpackage

FILE: hdl/vcc_stream_if.sv
// ----------------------------------------------------------------------------
// Vector clock compare channels
// Valid/ready channels for the command beats and the result beats.
// ----------------------------------------------------------------------------
interface vcc_in_if;
    logic                      valid;
    logic                      ready;
    logic [vcc_pkg::OP_W-1:0]   opcode;
    logic [vcc_pkg::NODE_W-1:0] node_id;
    logic [vcc_pkg::CNT_W-1:0]  counter;

    modport source (output valid, output opcode, output node_id, output counter,
                    input ready);
    modport sink   (input valid, input opcode, input node_id, input counter,
                    output ready);
endinterface

interface vcc_out_if;
    logic                      valid;
    logic                      ready;
    logic [vcc_pkg::REL_W-1:0] relation;
    logic                      overflow;

    modport source (output valid, output relation, output overflow, input ready);
    modport sink   (input valid, input relation, input overflow, output ready);
endinterface

FILE: hdl/vcc_store.sv
// ----------------------------------------------------------------------------
// Vector clock entry store
// Single-write, single-read memory of clock entries with registered read data.
// ----------------------------------------------------------------------------
module vcc_store #(
    parameter int DEPTH = vcc_pkg::MAX_ENTRIES_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic            i_clk,
    input  logic            i_wr_en,
    input  logic [AW-1:0]   i_wr_addr,
    input  vcc_pkg::t_entry i_wr_data,
    input  logic [AW-1:0]   i_rd_addr,
    output vcc_pkg::t_entry o_rd_data
);
    import vcc_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port; the address is read every cycle.
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hdl/vcc_cmp.sv
// ----------------------------------------------------------------------------
// Vector clock step comparator
// Compares the current A and B entries: node ids and counters both ways.
// ----------------------------------------------------------------------------
module vcc_cmp (
    input  vcc_pkg::t_entry   i_a,
    input  vcc_pkg::t_entry   i_b,
    output vcc_pkg::t_cmp_res o_res
);
    import vcc_pkg::*;

    // An id equality and an id less-than compare, and one counter magnitude compare in each direction.
    always_comb begin
        o_res.id_eq    = (i_a.node_id == i_b.node_id);
        o_res.id_a_lt  = (i_a.node_id <  i_b.node_id);
        o_res.cnt_a_gt = (i_a.counter >  i_b.counter);
        o_res.cnt_b_gt = (i_b.counter >  i_a.counter);
    end

endmodule

FILE: hdl/vector_clock_compare.sv
// ----------------------------------------------------------------------------
// Vector clock compare
// Loads two vector clocks entry by entry and compares them by a merge walk.
// ----------------------------------------------------------------------------
// Usage:
// Command beats arrive on i_in. A clear or append beat updates the clocks
// and produces no result. An append to a clock that already holds
// MAX_ENTRIES entries is dropped and sets the overflow flag until the next
// clear. A compare beat starts a walk over both entry stores; the walk takes
// at most a_length + b_length merge steps, then the walk state detects the
// end of a list and the final state loads the result beat (relation,
// overflow). The walk speed is set by the single registered read port of
// each store feeding the shared step comparator.
// i_in.ready is high only while no compare is in flight; appends and clears
// are still taken while a result waits on o_out. If the receiver stalls, a
// finished compare holds in its final state until the result register frees.
// Reset empties both clocks and clears the overflow flag and the result
// valid flag; the stored entries and the result payload are not cleared.
// ----------------------------------------------------------------------------
module vector_clock_compare #(
    parameter int MAX_ENTRIES = vcc_pkg::MAX_ENTRIES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    vcc_in_if.sink    i_in,
    vcc_out_if.source o_out
);
    import vcc_pkg::*;

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int LW = $clog2(MAX_ENTRIES + 1);
    localparam logic [LW-1:0] FULL = LW'(MAX_ENTRIES);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state          r_state, n_state;
    logic [LW-1:0]   r_a_len, n_a_len;
    logic [LW-1:0]   r_b_len, n_b_len;
    logic            r_dropped, n_dropped;
    logic [LW-1:0]   r_ia, n_ia;
    logic [LW-1:0]   r_ib, n_ib;
    logic            r_a_big, n_a_big;
    logic            r_b_big, n_b_big;
    logic            r_out_valid, n_out_valid;
    t_relation       r_relation, n_relation;
    logic            r_overflow, n_overflow;

    logic            in_acc;
    t_opcode         op;
    logic            wr_a, wr_b;
    t_entry          wr_data;
    t_entry          a_data, b_data;
    t_cmp_res        cmp;
    logic            both_live;

    assign in_acc  = i_in.valid && i_in.ready;
    assign op      = t_opcode'(i_in.opcode);
    assign wr_data = '{node_id: i_in.node_id, counter: i_in.counter};
    assign wr_a    = in_acc && (op == OP_APPEND_A) && (r_a_len != FULL);
    assign wr_b    = in_acc && (op == OP_APPEND_B) && (r_b_len != FULL);

    // Entry stores of clock A and clock B.
    vcc_store #(.DEPTH(MAX_ENTRIES), .AW(AW)) u_store_a (
        .i_clk     (i_clk),
        .i_wr_en   (wr_a),
        .i_wr_addr (r_a_len[AW-1:0]),
        .i_wr_data (wr_data),
        .i_rd_addr (n_ia[AW-1:0]),
        .o_rd_data (a_data)
    );

    vcc_store #(.DEPTH(MAX_ENTRIES), .AW(AW)) u_store_b (
        .i_clk     (i_clk),
        .i_wr_en   (wr_b),
        .i_wr_addr (r_b_len[AW-1:0]),
        .i_wr_data (wr_data),
        .i_rd_addr (n_ib[AW-1:0]),
        .o_rd_data (b_data)
    );

    // Shared comparator for the current pair of entries.
    vcc_cmp u_cmp (
        .i_a   (a_data),
        .i_b   (b_data),
        .o_res (cmp)
    );

    assign both_live = (r_ia < r_a_len) && (r_ib < r_b_len);

    // Sequencer: command decode, merge walk and result hand-off.
    always_comb begin
        n_state     = r_state;
        n_a_len     = r_a_len;
        n_b_len     = r_b_len;
        n_dropped   = r_dropped;
        n_ia        = r_ia;
        n_ib        = r_ib;
        n_a_big     = r_a_big;
        n_b_big     = r_b_big;
        n_out_valid = r_out_valid && !o_out.ready;
        n_relation  = r_relation;
        n_overflow  = r_overflow;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (op)
                        OP_CLEAR: begin
                            n_a_len   = '0;
                            n_b_len   = '0;
                            n_dropped = 1'b0;
                        end
                        OP_APPEND_A: begin
                            if (r_a_len == FULL) begin
                                n_dropped = 1'b1;
                            end else begin
                                n_a_len = r_a_len + LW'(1);
                            end
                        end
                        OP_APPEND_B: begin
                            if (r_b_len == FULL) begin
                                n_dropped = 1'b1;
                            end else begin
                                n_b_len = r_b_len + LW'(1);
                            end
                        end
                        OP_COMPARE: begin
                            n_ia    = '0;
                            n_ib    = '0;
                            n_a_big = 1'b0;
                            n_b_big = 1'b0;
                            n_state = S_WALK;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_WALK: begin
                if (both_live) begin
                    // One merge step on the entries read last cycle.
                    if (cmp.id_eq) begin
                        if (cmp.cnt_a_gt) begin
                            n_a_big = 1'b1;
                        end else if (cmp.cnt_b_gt) begin
                            n_b_big = 1'b1;
                        end
                        n_ia = r_ia + LW'(1);
                        n_ib = r_ib + LW'(1);
                    end else if (cmp.id_a_lt) begin
                        n_a_big = 1'b1;
                        n_ia    = r_ia + LW'(1);
                    end else begin
                        n_b_big = 1'b1;
                        n_ib    = r_ib + LW'(1);
                    end
                end else begin
                    // Leftover entries on either side count as bigger.
                    if (r_ia < r_a_len) begin
                        n_a_big = 1'b1;
                    end else if (r_ib < r_b_len) begin
                        n_b_big = 1'b1;
                    end
                    n_state = S_DONE;
                end
            end

            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_overflow  = r_dropped;
                    if (r_a_big && r_b_big) begin
                        n_relation = REL_CONCURRENT;
                    end else if (r_a_big) begin
                        n_relation = REL_AFTER;
                    end else if (r_b_big) begin
                        n_relation = REL_BEFORE;
                    end else begin
                        n_relation = REL_EQUAL;
                    end
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_a_len     <= '0;
            r_b_len     <= '0;
            r_dropped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_a_len     <= n_a_len;
            r_b_len     <= n_b_len;
            r_dropped   <= n_dropped;
            r_out_valid <= n_out_valid;
        end
    end

    // Walk indices, flags and result payload.
    always_ff @(posedge i_clk) begin
        r_ia       <= n_ia;
        r_ib       <= n_ib;
        r_a_big    <= n_a_big;
        r_b_big    <= n_b_big;
        r_relation <= n_relation;
        r_overflow <= n_overflow;
    end

    assign i_in.ready     = (r_state == S_IDLE);
    assign o_out.valid    = r_out_valid;
    assign o_out.relation = r_relation;
    assign o_out.overflow = r_overflow;

`ifndef SYNTHESIS
    // Neither clock ever holds more than its capacity.
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_len <= FULL) && (r_b_len <= FULL))
        else $error("clock length exceeds capacity");

    // The walk indices never run past the list lengths.
    walk_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> ((r_ia <= r_a_len) && (r_ib <= r_b_len)))
        else $error("walk index past list end");

    // A taken compare starts the walk on the next cycle.
    cmp_starts_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (op == OP_COMPARE)) |=> (r_state == S_WALK))
        else $error("compare did not start a walk");

    // The lists do not change while a walk is running.
    len_stable_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |=> ($stable(r_a_len) && $stable(r_b_len)))
        else $error("list length changed during a walk");

    // A result is only ever loaded from the final state of a walk.
    result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid && n_out_valid) |-> (r_state == S_DONE))
        else $error("result loaded outside a compare");
`endif

endmodule

FILE: sim/vector_clock_compare_tb.sv
// ----------------------------------------------------------------------------
// Vector clock compare testbench
// Feeds clear, append and compare beats into the comparator and checks each
// result beat against an in-bench prediction of both clocks. A directed
// opening covers empty, full, extreme and out-of-order clocks; random clock
// pairs follow, with random stalls on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vector_clock_compare_tb;
    import vcc_pkg::*;

    localparam int CAP            = MAX_ENTRIES_DEF;
    localparam int RANDOM_ITEMS   = 900;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int TAIL_CYCLES    = 2 * CAP + 16;

    // Shapes of a random clock pair.
    typedef enum int {
        SHAPE_EQUAL,
        SHAPE_A_AHEAD,
        SHAPE_B_AHEAD,
        SHAPE_MIXED
    } vc_shape_t;

    // One command beat with its pacing marks.
    typedef struct {
        t_opcode           op;
        logic [NODE_W-1:0] node_id;
        logic [CNT_W-1:0]  counter;
        bit                stall_rx;
        bit                drain;
    } vc_cmd_t;

    // One expected result beat.
    typedef struct {
        t_relation relation;
        logic      overflow;
    } vc_answer_t;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // Command channel drive.
    logic              in_valid = 1'b0;
    logic [OP_W-1:0]   in_op    = '0;
    logic [NODE_W-1:0] in_node  = '0;
    logic [CNT_W-1:0]  in_cnt   = '0;
    logic              ans_ready = 1'b0;

    vc_cmd_t    cmd_q[$];
    vc_cmd_t    in_cur;
    vc_answer_t pending_answers[$];

    // Predicted contents of both clocks.
    t_entry clk_a[CAP];
    t_entry clk_b[CAP];
    int     len_a   = 0;
    int     len_b   = 0;
    bit     dropped = 1'b0;

    bit stall_armed = 1'b0;
    bit drain_armed = 1'b0;
    bit in_fire     = 1'b0;
    int beats_in    = 0;
    int stall_marks = 0;
    int stall_seen  = 0;
    int rx_hold     = 0;
    int idle_cycles = 0;
    int n_fail      = 0;

    vcc_in_if  cmd_if ();
    vcc_out_if ans_if ();

    assign cmd_if.valid   = in_valid;
    assign cmd_if.opcode  = in_op;
    assign cmd_if.node_id = in_node;
    assign cmd_if.counter = in_cnt;
    assign ans_if.ready   = ans_ready;

    vector_clock_compare #(
        .MAX_ENTRIES(CAP)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (cmd_if),
        .o_out  (ans_if)
    );

    // Free-running clock.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Merge walk over both predicted clocks.
    function automatic t_relation clock_ordering();
        int ia;
        int ib;
        bit a_big;
        bit b_big;
        ia    = 0;
        ib    = 0;
        a_big = 1'b0;
        b_big = 1'b0;
        while (ia < len_a && ib < len_b) begin
            if (clk_a[ia].node_id == clk_b[ib].node_id) begin
                if (clk_a[ia].counter > clk_b[ib].counter) begin
                    a_big = 1'b1;
                end else if (clk_b[ib].counter > clk_a[ia].counter) begin
                    b_big = 1'b1;
                end
                ia++;
                ib++;
            end else if (clk_a[ia].node_id > clk_b[ib].node_id) begin
                b_big = 1'b1;
                ib++;
            end else begin
                a_big = 1'b1;
                ia++;
            end
        end
        // Leftover entries on either side count as a node the other lacks.
        if (ia < len_a) begin
            a_big = 1'b1;
        end else if (ib < len_b) begin
            b_big = 1'b1;
        end
        case ({a_big, b_big})
            2'b00:   return REL_EQUAL;
            2'b10:   return REL_AFTER;
            2'b01:   return REL_BEFORE;
            default: return REL_CONCURRENT;
        endcase
    endfunction

    // Update the predicted clocks for one accepted beat.
    task automatic track_clocks(input vc_cmd_t c);
        vc_answer_t a;
        case (c.op)
            OP_CLEAR: begin
                len_a   = 0;
                len_b   = 0;
                dropped = 1'b0;
            end
            OP_APPEND_A: begin
                if (len_a >= CAP) begin
                    dropped = 1'b1;
                end else begin
                    clk_a[len_a] = '{node_id: c.node_id, counter: c.counter};
                    len_a++;
                end
            end
            OP_APPEND_B: begin
                if (len_b >= CAP) begin
                    dropped = 1'b1;
                end else begin
                    clk_b[len_b] = '{node_id: c.node_id, counter: c.counter};
                    len_b++;
                end
            end
            default: begin
                a.relation = clock_ordering();
                a.overflow = dropped;
                pending_answers.push_back(a);
            end
        endcase
    endtask

    function automatic logic [CNT_W-1:0] rand_count();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return '0;
            1:       return '1;
            2:       return CNT_W'($urandom_range(0, 15));
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    // Queue one command, marking the receiver hold-off and the drain pause.
    task automatic push_cmd(input t_opcode op, input int unsigned id,
                            input logic [CNT_W-1:0] cnt);
        vc_cmd_t c;
        c.op       = op;
        c.node_id  = id[NODE_W-1:0];
        c.counter  = cnt;
        c.stall_rx = (op == OP_COMPARE) && !stall_armed && cmd_q.size() >= 250;
        c.drain    = !drain_armed && cmd_q.size() >= 450;
        if (c.stall_rx) stall_armed = 1'b1;
        if (c.drain) drain_armed = 1'b1;
        cmd_q.push_back(c);
    endtask

    // Build a pair of vector clocks over one ascending id set, load them interleaved and
    // compare; sometimes a stray append and a second compare follow.
    task automatic queue_clock_pair(input int force_n, input bit fixed_shape,
                                    input vc_shape_t shape_in);
        int               n_ids;
        int               step_max;
        int               id;
        int               r;
        int               d;
        vc_shape_t        shape;
        logic [CNT_W-1:0] ca;
        logic [CNT_W-1:0] cb;
        t_entry           ents_a[$];
        t_entry           ents_b[$];
        t_entry           e;
        if (force_n >= 0) begin
            n_ids = force_n;
        end else if ($urandom_range(0, 9) == 0) begin
            n_ids = $urandom_range(14, 20);
        end else begin
            n_ids = $urandom_range(0, 8);
        end
        shape    = fixed_shape ? shape_in : vc_shape_t'($urandom_range(0, 3));
        step_max = 32767 / (n_ids + 1);
        id       = $urandom_range(0, step_max);
        for (int k = 0; k < n_ids; k++) begin
            ca = rand_count();
            d  = $urandom_range(0, 3);
            r  = $urandom_range(0, 99);
            case (shape)
                SHAPE_EQUAL: begin
                    cb = ca;
                    r  = 0;
                end
                SHAPE_A_AHEAD: begin
                    cb = (ca >= CNT_W'(d)) ? ca - CNT_W'(d) : ca;
                    r  = (r < 75) ? 0 : 60;
                end
                SHAPE_B_AHEAD: begin
                    cb = ca;
                    ca = (cb >= CNT_W'(d)) ? cb - CNT_W'(d) : cb;
                    r  = (r < 75) ? 0 : 80;
                end
                default: begin
                    cb = ($urandom_range(0, 1) == 0) ? ca : rand_count();
                end
            endcase
            // Both sides below 60, A alone below 80, B alone above.
            if (r < 80) ents_a.push_back('{node_id: NODE_W'(id), counter: ca});
            if (r < 60 || r >= 80) ents_b.push_back('{node_id: NODE_W'(id), counter: cb});
            id += $urandom_range(1, step_max);
        end
        if ($urandom_range(0, 99) < 85) begin
            push_cmd(OP_CLEAR, $urandom_range(0, 32767), rand_count());
        end
        while (ents_a.size() != 0 || ents_b.size() != 0) begin
            if (ents_b.size() == 0 || (ents_a.size() != 0 && $urandom_range(0, 1) == 0)) begin
                e = ents_a.pop_front();
                push_cmd(OP_APPEND_A, e.node_id, e.counter);
            end else begin
                e = ents_b.pop_front();
                push_cmd(OP_APPEND_B, e.node_id, e.counter);
            end
        end
        push_cmd(OP_COMPARE, $urandom_range(0, 32767), rand_count());
        if ($urandom_range(0, 99) < 30) begin
            push_cmd(($urandom_range(0, 1) == 0) ? OP_APPEND_A : OP_APPEND_B,
                     $urandom_range(0, 32767), rand_count());
            push_cmd(OP_COMPARE, $urandom_range(0, 32767), rand_count());
        end
    endtask

    function automatic bit quiet_stretch();
        return beats_in >= 600 && beats_in < 760;
    endfunction

    // Command driver: presents the next beat once the current one is taken.
    always @(negedge i_clk) begin : cmd_driver
        vc_cmd_t nxt;
        if (i_rst_n) begin
            if (!in_valid || in_fire) begin
                if (cmd_q.size() != 0 && (quiet_stretch() || $urandom_range(0, 99) >= 17)
                        && !(cmd_q[0].drain && pending_answers.size() != 0)) begin
                    nxt      = cmd_q.pop_front();
                    in_cur   = nxt;
                    in_valid <= 1'b1;
                    in_op    <= nxt.op;
                    in_node  <= nxt.node_id;
                    in_cnt   <= nxt.counter;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result receiver: random back-pressure plus one long hold-off.
    always @(negedge i_clk) begin : ans_pacer
        if (stall_seen != stall_marks) begin
            stall_seen = stall_marks;
            rx_hold    = RX_HOLD_CYCLES;
        end
        if (!i_rst_n) begin
            ans_ready <= 1'b0;
        end else if (rx_hold != 0) begin
            rx_hold--;
            ans_ready <= 1'b0;
        end else begin
            ans_ready <= quiet_stretch() || ($urandom_range(0, 99) >= 17);
        end
    end

    // Monitor: predicts on each command beat and checks each result beat.
    always @(posedge i_clk) begin : beat_monitor
        vc_answer_t want;
        bit         out_fire;
        in_fire  = 1'b0;
        out_fire = 1'b0;
        if (i_rst_n) begin
            if (ans_if.valid && ans_ready) begin
                out_fire = 1'b1;
                if (pending_answers.size() == 0) begin
                    $error("unexpected result beat: relation %0d overflow %0d",
                           ans_if.relation, ans_if.overflow);
                    n_fail++;
                end else begin
                    want = pending_answers.pop_front();
                    if (ans_if.relation !== want.relation) begin
                        $error("relation: expected %0d, actual %0d",
                               want.relation, ans_if.relation);
                        n_fail++;
                    end
                    if (ans_if.overflow !== want.overflow) begin
                        $error("overflow: expected %0d, actual %0d",
                               want.overflow, ans_if.overflow);
                        n_fail++;
                    end
                end
            end
            if (in_valid && cmd_if.ready) begin
                in_fire = 1'b1;
                track_clocks(in_cur);
                beats_in++;
                if (in_cur.stall_rx) stall_marks++;
            end
            idle_cycles = (in_fire || out_fire) ? 0 : idle_cycles + 1;
        end
    end

    // Watchdog on cycles without any beat.
    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("RESULT: ERROR");
        $finish;
    end

    // Stimulus, reset and end of run.
    initial begin
        // Directed opening: empty, extremes, one-sided, concurrent, unordered.
        push_cmd(OP_COMPARE, 0, '0);
        push_cmd(OP_APPEND_A, 0, '0);
        push_cmd(OP_COMPARE, 0, '0);
        push_cmd(OP_APPEND_B, 0, '0);
        push_cmd(OP_COMPARE, 32767, '1);
        push_cmd(OP_APPEND_A, 32767, '1);
        push_cmd(OP_APPEND_B, 32767, ~64'd1);
        push_cmd(OP_COMPARE, 0, '0);
        push_cmd(OP_CLEAR, 32767, '1);
        push_cmd(OP_APPEND_B, 5, 64'd1);
        push_cmd(OP_COMPARE, 0, '0);
        push_cmd(OP_CLEAR, 0, '0);
        push_cmd(OP_APPEND_A, 1, 64'd10);
        push_cmd(OP_APPEND_A, 3, 64'd5);
        push_cmd(OP_APPEND_B, 1, 64'd5);
        push_cmd(OP_APPEND_B, 3, 64'd10);
        push_cmd(OP_COMPARE, 0, '0);
        push_cmd(OP_CLEAR, 0, '0);
        push_cmd(OP_APPEND_A, 9, 64'd1);
        push_cmd(OP_APPEND_A, 2, 64'd1);
        push_cmd(OP_APPEND_B, 2, 64'd1);
        push_cmd(OP_APPEND_B, 9, 64'd1);
        push_cmd(OP_COMPARE, 0, '0);
        push_cmd(OP_CLEAR, 0, '0);
        push_cmd(OP_COMPARE, 0, '0);

        // Both clocks overfilled with identical entries, then random pairs and short runs of random commands.
        queue_clock_pair(CAP + 4, 1'b1, SHAPE_EQUAL);
        while (cmd_q.size() < 25 + RANDOM_ITEMS) begin
            if ($urandom_range(0, 99) < 10) begin
                repeat ($urandom_range(1, 4)) begin
                    push_cmd(t_opcode'($urandom_range(0, 3)), $urandom_range(0, 32767),
                             rand_count());
                end
            end else begin
                queue_clock_pair(-1, 1'b0, SHAPE_MIXED);
            end
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_q.size() != 0 || in_valid) @(posedge i_clk);
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (pending_answers.size() != 0) begin
            $error("%0d expected results never arrived", pending_answers.size());
            n_fail++;
        end
        if (n_fail == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
